FILE: design/gmfe_pkg.sv
// Shared types, constants and coefficient tables of the Gaussian mixture Fourier evaluator.
`default_nettype none
package gmfe_pkg;

  localparam int MAX_COMP = 16;
  localparam int IDX_W    = (MAX_COMP > 1) ? $clog2(MAX_COMP) : 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_COUNT    = 2'd2;

  localparam logic [31:0] ONE_Q30       = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30   = 32'd1686629713;
  localparam logic [31:0] TWO_PI_SQ_Q24 = 32'd331168970;
  localparam logic [31:0] LOG2E_Q30     = 32'd1549082005;
  localparam logic [31:0] LN2_Q30       = 32'd744261118;
  localparam longint      EXP_FLOOR_Q24 = -64'sd536870912;
  localparam longint      EXP_CEIL_Q24  = 64'sd134217728;
  localparam longint      QUAD_LIM_Q24  = 64'sd268435456;
  localparam logic [32:0] SUM_MAX       = 33'h1_FFFF_FFFF;

  // Horner steps: exp uses 0..10 (k = 11..1), sine 11..17, cosine 18..25
  localparam int HX_COUNT = 26;
  localparam logic [4:0] HX_EXP_FIRST = 5'd0;
  localparam logic [4:0] HX_EXP_LAST  = 5'd10;
  localparam logic [4:0] HX_SIN_FIRST = 5'd11;
  localparam logic [4:0] HX_SIN_LAST  = 5'd17;
  localparam logic [4:0] HX_COS_FIRST = 5'd18;
  localparam logic [4:0] HX_COS_LAST  = 5'd25;

  localparam logic [32:0] RCP_NUM = 33'h0_FFFF_FFFF;

  localparam logic [7:0] HORNER_DIV [HX_COUNT] = '{
    8'd11, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1,
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
    8'd240, 8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };

  // floor((2^32-1)/d): estimate is at most one low, fixed by a remainder check
  localparam logic [31:0] HORNER_RCP [HX_COUNT] = '{
    32'(RCP_NUM / 33'd11), 32'(RCP_NUM / 33'd10), 32'(RCP_NUM / 33'd9),
    32'(RCP_NUM / 33'd8),  32'(RCP_NUM / 33'd7),  32'(RCP_NUM / 33'd6),
    32'(RCP_NUM / 33'd5),  32'(RCP_NUM / 33'd4),  32'(RCP_NUM / 33'd3),
    32'(RCP_NUM / 33'd2),  32'(RCP_NUM / 33'd1),
    32'(RCP_NUM / 33'd210), 32'(RCP_NUM / 33'd156), 32'(RCP_NUM / 33'd110),
    32'(RCP_NUM / 33'd72),  32'(RCP_NUM / 33'd42),  32'(RCP_NUM / 33'd20),
    32'(RCP_NUM / 33'd6),
    32'(RCP_NUM / 33'd240), 32'(RCP_NUM / 33'd182), 32'(RCP_NUM / 33'd132),
    32'(RCP_NUM / 33'd90),  32'(RCP_NUM / 33'd56),  32'(RCP_NUM / 33'd30),
    32'(RCP_NUM / 33'd12),  32'(RCP_NUM / 33'd2)
  };

  typedef struct packed {
    logic               operation;
    logic [3:0]         comp_index;
    logic [30:0]        amp_value;
    logic signed [31:0] cov_a;
    logic signed [31:0] cov_b;
    logic signed [31:0] cov_d;
    logic signed [31:0] freq_v;
    logic signed [31:0] freq_w;
  } item_t;

  typedef struct packed {
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
  } result_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [30:0]        amp;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] d;
  } comp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage
`default_nettype wire

FILE: design/gmfe_ifs.sv
// Valid/ready channel interfaces for items, results and register writes.
`default_nettype none
interface gmfe_item_if;
  logic            valid;
  logic            ready;
  gmfe_pkg::item_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface gmfe_result_if;
  logic              valid;
  logic              ready;
  gmfe_pkg::result_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface gmfe_cfg_if;
  logic           valid;
  logic           ready;
  gmfe_pkg::cfg_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

FILE: design/gmfe_mul.sv
// Shared signed 34x34 multiplier with registered product.
`default_nettype none
module gmfe_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

FILE: design/gmfe_tbl.sv
// Component table: one write port, one registered read port.
`default_nettype none
module gmfe_tbl (
  input  logic                       clk,
  input  logic                       we,
  input  logic [gmfe_pkg::IDX_W-1:0] waddr,
  input  gmfe_pkg::comp_t            wcomp,
  input  logic [gmfe_pkg::IDX_W-1:0] raddr,
  output gmfe_pkg::comp_t            rcomp
);

  gmfe_pkg::comp_t mem [gmfe_pkg::MAX_COMP];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wcomp;
    end
    rcomp <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/gmfe_core.sv
// Sequencer and datapath of one evaluation around the shared multiplier.
`default_nettype none
module gmfe_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [31:0]         freq_v,
  input  logic signed [31:0]         freq_w,
  input  logic signed [31:0]         offset_x,
  input  logic signed [31:0]         offset_y,
  input  logic [4:0]                 comp_count,
  input  logic                       res_free,
  output logic [gmfe_pkg::IDX_W-1:0] rd_addr,
  input  gmfe_pkg::comp_t            rd_comp,
  output gmfe_pkg::core_stat_t       stat,
  output logic signed [31:0]         real_part,
  output logic signed [31:0]         imag_part
);

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_VV     = 6'd1;
  localparam logic [5:0] S_VW     = 6'd2;
  localparam logic [5:0] S_WW     = 6'd3;
  localparam logic [5:0] S_PX     = 6'd4;
  localparam logic [5:0] S_PY     = 6'd5;
  localparam logic [5:0] S_PH     = 6'd6;
  localparam logic [5:0] S_TH     = 6'd7;
  localparam logic [5:0] S_T2     = 6'd8;
  localparam logic [5:0] S_T2C    = 6'd9;
  localparam logic [5:0] S_HMUL   = 6'd10;
  localparam logic [5:0] S_HM0    = 6'd11;
  localparam logic [5:0] S_HQ0    = 6'd12;
  localparam logic [5:0] S_HREM   = 6'd13;
  localparam logic [5:0] S_SINI   = 6'd14;
  localparam logic [5:0] S_SINC   = 6'd15;
  localparam logic [5:0] S_ROT    = 6'd16;
  localparam logic [5:0] S_CSTART = 6'd17;
  localparam logic [5:0] S_CRD    = 6'd18;
  localparam logic [5:0] S_QA     = 6'd19;
  localparam logic [5:0] S_QB     = 6'd20;
  localparam logic [5:0] S_QD     = 6'd21;
  localparam logic [5:0] S_QS     = 6'd22;
  localparam logic [5:0] S_X      = 6'd23;
  localparam logic [5:0] S_XC     = 6'd24;
  localparam logic [5:0] S_Y      = 6'd25;
  localparam logic [5:0] S_YC     = 6'd26;
  localparam logic [5:0] S_R      = 6'd27;
  localparam logic [5:0] S_ESH    = 6'd28;
  localparam logic [5:0] S_AMP    = 6'd29;
  localparam logic [5:0] S_ACC    = 6'd30;
  localparam logic [5:0] S_NEXT   = 6'd31;
  localparam logic [5:0] S_RE     = 6'd32;
  localparam logic [5:0] S_IM     = 6'd33;
  localparam logic [5:0] S_FIN    = 6'd34;
  localparam logic [5:0] S_DONE   = 6'd35;

  localparam int KW = gmfe_pkg::IDX_W;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic [5:0]         state;
  logic [5:0]         state_next;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;

  logic signed [31:0] v, w, pvv, pvw, pww;
  logic [47:0]        phacc;
  logic [31:0]        ph;
  logic [31:0]        th, hmul, hz, m0, q0, sv, e;
  logic [4:0]         hidx;
  logic signed [31:0] co, si, re, im;
  logic [KW-1:0]      k;
  logic signed [51:0] acc;
  logic signed [29:0] qn;
  logic signed [30:0] xc;
  logic signed [7:0]  n;
  logic [32:0]        s;

  logic [KW:0]        cnt_eff;
  logic [KW:0]        k_inc;
  logic [47:0]        ph_neg;
  logic [31:0]        hq_rem;
  logic [7:0]         hdiv;
  logic [32:0]        hq;
  logic [31:0]        hz_upd;
  logic signed [67:0] xw;
  logic               x_under;
  logic signed [51:0] acc_f;
  logic signed [29:0] qn_next;
  logic signed [8:0]  rsh;
  logic [32:0]        el;
  logic [31:0]        e_next;
  logic [38:0]        acc_sum;

  gmfe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  assign rd_addr = k;
  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);
  assign real_part = re;
  assign imag_part = im;

  always_comb begin
    if (32'(comp_count) > 32'(gmfe_pkg::MAX_COMP)) begin
      cnt_eff = (KW+1)'(gmfe_pkg::MAX_COMP);
    end else begin
      cnt_eff = (KW+1)'(comp_count);
    end
  end

  assign k_inc  = {1'b0, k} + (KW+1)'(1);
  assign ph_neg = 48'd0 - (phacc + prod[47:0]);

  // divide-by-constant correction: remainder at or above divisor bumps the quotient
  assign hdiv   = gmfe_pkg::HORNER_DIV[hidx];
  assign hq_rem = m0 - prod[31:0];
  assign hq     = {1'b0, q0} + ((hq_rem >= {24'd0, hdiv}) ? 33'd1 : 33'd0);

  always_comb begin
    if (hidx <= gmfe_pkg::HX_EXP_LAST) begin
      hz_upd = 32'({1'b0, gmfe_pkg::ONE_Q30} + hq);
    end else if (hq > {1'b0, gmfe_pkg::ONE_Q30}) begin
      hz_upd = 32'd0;
    end else begin
      hz_upd = 32'({1'b0, gmfe_pkg::ONE_Q30} - hq);
    end
  end

  assign xw      = prod >>> 24;
  assign x_under = (xw < 68'(gmfe_pkg::EXP_FLOOR_Q24));
  assign acc_f   = acc + 52'(prod >>> 16);

  always_comb begin
    if (acc_f > 52'(gmfe_pkg::QUAD_LIM_Q24)) begin
      qn_next = 30'(-gmfe_pkg::QUAD_LIM_Q24);
    end else if (acc_f < 52'(-gmfe_pkg::QUAD_LIM_Q24)) begin
      qn_next = 30'(gmfe_pkg::QUAD_LIM_Q24);
    end else begin
      qn_next = 30'(-acc_f);
    end
  end

  // scale the Horner result by 2^(n-6) with saturation
  assign rsh = 9'sd6 - 9'(n);
  assign el  = {1'b0, hz} << ((n == 8'sd7) ? 1 : 0);
  always_comb begin
    if (n >= 8'sd8) begin
      e_next = 32'hFFFF_FFFF;
    end else if (n >= 8'sd6) begin
      e_next = (el > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : el[31:0];
    end else if (rsh >= 9'sd32) begin
      e_next = 32'd0;
    end else begin
      e_next = hz >> rsh[4:0];
    end
  end

  assign acc_sum = {6'd0, s} + {1'b0, prod[62:25]};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    unique case (state)
      S_VV:    begin mul_a = 34'(v);              mul_b = 34'(v); end
      S_VW:    begin mul_a = 34'(v);              mul_b = 34'(w); end
      S_WW:    begin mul_a = 34'(w);              mul_b = 34'(w); end
      S_PX:    begin mul_a = 34'(offset_x);       mul_b = 34'(v); end
      S_PY:    begin mul_a = 34'(offset_y);       mul_b = 34'(w); end
      S_TH:    begin mul_a = 34'(ph[29:0]);       mul_b = 34'(gmfe_pkg::HALF_PI_Q30); end
      S_T2:    begin mul_a = 34'(prod[61:30]);    mul_b = 34'(prod[61:30]); end
      S_HMUL:  begin mul_a = 34'(hmul);           mul_b = 34'(hz); end
      S_HM0:   begin
        mul_a = 34'(prod[61:30]);
        mul_b = 34'(gmfe_pkg::HORNER_RCP[hidx]);
      end
      S_HQ0:   begin mul_a = 34'(prod[63:32]);    mul_b = 34'(hdiv); end
      S_SINI:  begin mul_a = 34'(th);             mul_b = 34'(hz); end
      S_QA:    begin mul_a = 34'(rd_comp.a);      mul_b = 34'(pvv); end
      S_QB:    begin mul_a = 34'(rd_comp.b);      mul_b = 34'(pvw); end
      S_QD:    begin mul_a = 34'(rd_comp.d);      mul_b = 34'(pww); end
      S_X:     begin mul_a = 34'(qn);             mul_b = 34'(gmfe_pkg::TWO_PI_SQ_Q24); end
      S_Y:     begin mul_a = 34'(xc);             mul_b = 34'(gmfe_pkg::LOG2E_Q30); end
      S_YC:    begin mul_a = 34'(prod[53:30]);    mul_b = 34'(gmfe_pkg::LN2_Q30); end
      S_AMP:   begin mul_a = 34'(rd_comp.amp);    mul_b = 34'(e); end
      S_RE:    begin mul_a = 34'(s);              mul_b = 34'(co); end
      S_IM:    begin mul_a = 34'(s);              mul_b = 34'(si); end
      default: begin mul_a = 34'sd0;              mul_b = 34'sd0; end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   state_next = start ? S_VV : S_IDLE;
      S_VV:     state_next = S_VW;
      S_VW:     state_next = S_WW;
      S_WW:     state_next = S_PX;
      S_PX:     state_next = S_PY;
      S_PY:     state_next = S_PH;
      S_PH:     state_next = S_TH;
      S_TH:     state_next = S_T2;
      S_T2:     state_next = S_T2C;
      S_T2C:    state_next = S_HMUL;
      S_HMUL:   state_next = S_HM0;
      S_HM0:    state_next = S_HQ0;
      S_HQ0:    state_next = S_HREM;
      S_HREM: begin
        if (hidx == gmfe_pkg::HX_EXP_LAST) begin
          state_next = S_ESH;
        end else if (hidx == gmfe_pkg::HX_SIN_LAST) begin
          state_next = S_SINI;
        end else if (hidx == gmfe_pkg::HX_COS_LAST) begin
          state_next = S_ROT;
        end else begin
          state_next = S_HMUL;
        end
      end
      S_SINI:   state_next = S_SINC;
      S_SINC:   state_next = S_HMUL;
      S_ROT:    state_next = S_CSTART;
      S_CSTART: state_next = (cnt_eff == '0) ? S_RE : S_CRD;
      S_CRD:    state_next = S_QA;
      S_QA:     state_next = S_QB;
      S_QB:     state_next = S_QD;
      S_QD:     state_next = S_QS;
      S_QS:     state_next = S_X;
      S_X:      state_next = S_XC;
      S_XC:     state_next = x_under ? S_NEXT : S_Y;
      S_Y:      state_next = S_YC;
      S_YC:     state_next = S_R;
      S_R:      state_next = S_HMUL;
      S_ESH:    state_next = S_AMP;
      S_AMP:    state_next = S_ACC;
      S_ACC:    state_next = S_NEXT;
      S_NEXT:   state_next = (k_inc == cnt_eff) ? S_RE : S_CRD;
      S_RE:     state_next = S_IM;
      S_IM:     state_next = S_FIN;
      S_FIN:    state_next = S_DONE;
      S_DONE:   state_next = res_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          v <= freq_v;
          w <= freq_w;
        end
      end
      S_VW:   pvv <= sat32(prod >>> 24);
      S_WW:   pvw <= sat32(prod >>> 24);
      S_PX:   pww <= sat32(prod >>> 24);
      S_PY:   phacc <= prod[47:0];
      S_PH:   ph <= ph_neg[47:16];
      S_T2:   th <= prod[61:30];
      S_T2C: begin
        hmul <= prod[61:30];
        hz   <= gmfe_pkg::ONE_Q30;
        hidx <= gmfe_pkg::HX_SIN_FIRST;
      end
      S_HM0:  m0 <= prod[61:30];
      S_HQ0:  q0 <= prod[63:32];
      S_HREM: begin
        hz   <= hz_upd;
        hidx <= hidx + 5'd1;
      end
      S_SINC: begin
        sv   <= prod[61:30];
        hz   <= gmfe_pkg::ONE_Q30;
        hidx <= gmfe_pkg::HX_COS_FIRST;
      end
      S_ROT: begin
        unique case (ph[31:30])
          2'd0:    begin co <= $signed(hz);  si <= $signed(sv);  end
          2'd1:    begin co <= -$signed(sv); si <= $signed(hz);  end
          2'd2:    begin co <= -$signed(hz); si <= -$signed(sv); end
          default: begin co <= $signed(sv);  si <= -$signed(hz); end
        endcase
      end
      S_CSTART: begin
        s <= 33'd0;
        k <= '0;
      end
      S_QB:   acc <= 52'(prod >>> 16);
      S_QD:   acc <= acc + 52'(prod >>> 15);
      S_QS:   qn <= qn_next;
      S_XC: begin
        if (xw > 68'(gmfe_pkg::EXP_CEIL_Q24)) begin
          xc <= 31'(gmfe_pkg::EXP_CEIL_Q24);
        end else begin
          xc <= xw[30:0];
        end
      end
      S_YC:   n <= prod[61:54];
      S_R: begin
        hmul <= {2'b00, prod[53:24]};
        hz   <= gmfe_pkg::ONE_Q30;
        hidx <= gmfe_pkg::HX_EXP_FIRST;
      end
      S_ESH:  e <= e_next;
      S_ACC:  s <= (acc_sum > {6'd0, gmfe_pkg::SUM_MAX}) ? gmfe_pkg::SUM_MAX : acc_sum[32:0];
      S_NEXT: k <= k_inc[KW-1:0];
      S_IM:   re <= sat32(prod >>> 30);
      S_FIN:  im <= sat32(prod >>> 30);
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/gaussian_mixture_fourier_eval_top.sv
// Top level: Fourier transform of a 2-D Gaussian mixture at one frequency point.
//
//   channel  dir  word                                         handshake
//   item     in   operation, comp_index, amp_value, cov_a/b/d,  valid/ready
//                 freq_v, freq_w
//   result   out  real_part, imag_part                         valid/ready
//   cfg      in   reg_index, wdata                             valid/ready (ready always high)
//
// A load word writes the component table in the cycle it is accepted.
// An evaluate word is worked through by the single shared multiplier, component by component
//   (a component whose exponent underflows skips the exp steps and adds nothing):
//   every product, every Horner step of exp, sine and cosine, and every divide-by-constant
//   goes through it in turn. The next word can be taken once the result has loaded.
// Reset (rst, synchronous) clears the sequencer, the output valid and the registers
//   (offsets zero, count one); the table is not cleared.
// item.ready is low while an evaluation runs; a finished result waits in the core until the
//   output register is free, while the output register waits for result.ready.
`default_nettype none
module gaussian_mixture_fourier_eval_top (
  input  logic          clk,
  input  logic          rst,
  gmfe_item_if.sink     item,
  gmfe_result_if.source result,
  gmfe_cfg_if.sink      cfg
);

  // configuration registers
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic [4:0]         comp_count;

  logic                       item_take;
  logic                       tbl_we;
  logic                       start;
  logic                       res_free;
  logic [gmfe_pkg::IDX_W-1:0] rd_addr;
  gmfe_pkg::comp_t            wcomp;
  gmfe_pkg::comp_t            rd_comp;
  gmfe_pkg::core_stat_t       core_stat;
  logic signed [31:0]         core_re;
  logic signed [31:0]         core_im;

  // always take register writes; the sender must issue them only while idle (unchecked)
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= 32'sd0;
      offset_y   <= 32'sd0;
      comp_count <= 5'd1;
    end else if (cfg.valid) begin
      unique case (cfg.word.reg_index)
        gmfe_pkg::REG_OFFSET_X: offset_x   <= cfg.word.wdata;
        gmfe_pkg::REG_OFFSET_Y: offset_y   <= cfg.word.wdata;
        gmfe_pkg::REG_COUNT:    comp_count <= cfg.word.wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // hold off new words while the core is evaluating
  assign item.ready = !core_stat.busy;
  assign item_take  = item.valid && item.ready;
  assign start      = item_take && (item.word.operation == gmfe_pkg::OP_EVAL);

  // drop loads aimed past the table
  assign tbl_we = item_take && (item.word.operation == gmfe_pkg::OP_LOAD)
                  && (32'(item.word.comp_index) < 32'(gmfe_pkg::MAX_COMP));

  assign wcomp.amp = item.word.amp_value;
  assign wcomp.a   = item.word.cov_a;
  assign wcomp.b   = item.word.cov_b;
  assign wcomp.d   = item.word.cov_d;

  gmfe_tbl u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (gmfe_pkg::IDX_W'(item.word.comp_index)),
    .wcomp (wcomp),
    .raddr (rd_addr),
    .rcomp (rd_comp)
  );

  gmfe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .freq_v     (item.word.freq_v),
    .freq_w     (item.word.freq_w),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .comp_count (comp_count),
    .res_free   (res_free),
    .rd_addr    (rd_addr),
    .rd_comp    (rd_comp),
    .stat       (core_stat),
    .real_part  (core_re),
    .imag_part  (core_im)
  );

  // output register: free when empty or being drained this cycle
  assign res_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (core_stat.done && res_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_stat.done && res_free) begin
      result.word.real_part <= core_re;
      result.word.imag_part <= core_im;
    end
  end

  // a finished result moves into a free output register
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    core_stat.done && res_free |=> result.valid)
    else $error("finished result not presented");

  // an accepted evaluate word blocks the next one
  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.word.operation == gmfe_pkg::OP_EVAL |=> !item.ready)
    else $error("item taken during evaluation");

  // a result that cannot leave keeps the core waiting
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    core_stat.done && !res_free |=> core_stat.done)
    else $error("result dropped while output full");

endmodule
`default_nettype wire

FILE: test/tb_gaussian_mixture_fourier_eval_top.sv
// Self-checking testbench for the Gaussian mixture Fourier evaluator top level.
`default_nettype none
module tb_gaussian_mixture_fourier_eval_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAX_CYCLES  = 4_000_000;
  localparam int  PHASES      = 8;
  localparam int  PHASE_ITEMS = 180;
  localparam int  SETTLE      = 1200;
  localparam logic [1:0] REG_SPARE = 2'd3;   // no register behind this index

  // Keep the table and register copies, predict each evaluate word, hold the
  // predicted points until the block hands them back.
  class mixture_scoreboard;
    logic [30:0]        amp_copy [gmfe_pkg::MAX_COMP];
    logic signed [31:0] a_copy [gmfe_pkg::MAX_COMP];
    logic signed [31:0] b_copy [gmfe_pkg::MAX_COMP];
    logic signed [31:0] d_copy [gmfe_pkg::MAX_COMP];
    logic signed [31:0] mu_x, mu_y;
    logic [4:0]         count;
    gmfe_pkg::result_t  pending_points [$];
    int                 mismatches;
    int                 points_checked;

    function void reset_state();
      mu_x = '0;
      mu_y = '0;
      count = 5'd1;
      for (int k = 0; k < gmfe_pkg::MAX_COMP; k++) begin
        amp_copy[k] = '0;
        a_copy[k] = '0;
        b_copy[k] = '0;
        d_copy[k] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        gmfe_pkg::REG_OFFSET_X: mu_x = data;
        gmfe_pkg::REG_OFFSET_Y: mu_y = data;
        gmfe_pkg::REG_COUNT:    count = data[4:0];
        default: ;
      endcase
    endfunction

    static function longint clip(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // exp(x) with x in Q.24, answer unsigned Q8.24
    static function logic [63:0] exp_q24(longint x);
      longint      y, n;
      logic [63:0] f, r, p, e;
      if (x < gmfe_pkg::EXP_FLOOR_Q24) return 64'd0;
      if (x > gmfe_pkg::EXP_CEIL_Q24) x = gmfe_pkg::EXP_CEIL_Q24;
      y = (x * longint'(gmfe_pkg::LOG2E_Q30)) >>> 30;
      n = y >>> 24;
      f = 64'(y) & 64'hFF_FFFF;
      r = (f * 64'(gmfe_pkg::LN2_Q30)) >> 24;
      p = 64'(gmfe_pkg::ONE_Q30);
      for (int k = 11; k >= 1; k--)
        p = 64'(gmfe_pkg::ONE_Q30) + ((r * p) >> 30) / 64'(k);
      if (n >= 8) return 64'hFFFF_FFFF;
      if (n >= 6) e = p << (n - 6);
      else e = p >> (6 - n);
      return (e > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : e;
    endfunction

    static function void sin_cos(logic [31:0] ph, output longint co, output longint si);
      logic [63:0] th, t2, ps, pc, m;
      longint      c, s;
      th = (64'(ph[29:0]) * 64'(gmfe_pkg::HALF_PI_Q30)) >> 30;
      t2 = (th * th) >> 30;
      ps = 64'(gmfe_pkg::ONE_Q30);
      pc = 64'(gmfe_pkg::ONE_Q30);
      for (int k = 14; k >= 2; k -= 2) begin
        m = ((t2 * ps) >> 30) / 64'(k * (k + 1));
        ps = (m > 64'(gmfe_pkg::ONE_Q30)) ? 64'd0 : 64'(gmfe_pkg::ONE_Q30) - m;
      end
      for (int k = 15; k >= 1; k -= 2) begin
        m = ((t2 * pc) >> 30) / 64'(k * (k + 1));
        pc = (m > 64'(gmfe_pkg::ONE_Q30)) ? 64'd0 : 64'(gmfe_pkg::ONE_Q30) - m;
      end
      s = longint'((th * ps) >> 30);
      c = longint'(pc);
      case (ph[31:30])
        2'd0: begin co = c;  si = s;  end
        2'd1: begin co = -s; si = c;  end
        2'd2: begin co = -c; si = -s; end
        default: begin co = s; si = -c; end
      endcase
    endfunction

    function gmfe_pkg::result_t eval_point(logic signed [31:0] fv, logic signed [31:0] fw);
      longint            v, w, pvv, pvw, pww, q, x, co, si;
      logic [63:0]       s, ph;
      int                n;
      gmfe_pkg::result_t res;
      v = fv;
      w = fw;
      pvv = clip((v * v) >>> 24, -64'sd2147483648, 64'sd2147483647);
      pvw = clip((v * w) >>> 24, -64'sd2147483648, 64'sd2147483647);
      pww = clip((w * w) >>> 24, -64'sd2147483648, 64'sd2147483647);
      n = (count > gmfe_pkg::MAX_COMP) ? gmfe_pkg::MAX_COMP : count;
      s = '0;
      for (int k = 0; k < n; k++) begin
        q = ((longint'(a_copy[k]) * pvv) >>> 16) + ((longint'(b_copy[k]) * pvw) >>> 15)
          + ((longint'(d_copy[k]) * pww) >>> 16);
        q = clip(q, -gmfe_pkg::QUAD_LIM_Q24, gmfe_pkg::QUAD_LIM_Q24);
        x = (-(q * longint'(gmfe_pkg::TWO_PI_SQ_Q24))) >>> 24;
        s += (64'(amp_copy[k]) * exp_q24(x)) >> 25;
      end
      if (s > 64'(gmfe_pkg::SUM_MAX)) s = 64'(gmfe_pkg::SUM_MAX);
      ph = 64'(longint'(mu_x)) * 64'(v) + 64'(longint'(mu_y)) * 64'(w);
      ph = 64'd0 - ph;
      sin_cos(ph[47:16], co, si);
      res.real_part = 32'(clip((longint'(s) * co) >>> 30, -64'sd2147483648, 64'sd2147483647));
      res.imag_part = 32'(clip((longint'(s) * si) >>> 30, -64'sd2147483648, 64'sd2147483647));
      return res;
    endfunction

    function void note_item(gmfe_pkg::item_t it);
      if (it.operation == gmfe_pkg::OP_LOAD) begin
        amp_copy[it.comp_index] = it.amp_value;
        a_copy[it.comp_index] = it.cov_a;
        b_copy[it.comp_index] = it.cov_b;
        d_copy[it.comp_index] = it.cov_d;
      end else begin
        pending_points.push_back(eval_point(it.freq_v, it.freq_w));
      end
    endfunction

    function void check_word(gmfe_pkg::result_t got);
      gmfe_pkg::result_t want;
      if (pending_points.size() == 0) begin
        $error("result word with no point pending: real %0d imag %0d",
               got.real_part, got.imag_part);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      if (got.real_part !== want.real_part) begin
        $error("real_part: expected %0d, got %0d", want.real_part, got.real_part);
        mismatches++;
      end
      if (got.imag_part !== want.imag_part) begin
        $error("imag_part: expected %0d, got %0d", want.imag_part, got.imag_part);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  gmfe_item_if   item_ch ();
  gmfe_result_if res_ch ();
  gmfe_cfg_if    cfg_ch ();

  gaussian_mixture_fourier_eval_top DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  mixture_scoreboard sb;
  int  cycles;
  int  loads_sent, evals_sent, reg_writes;
  bit  calm;   // suppress all idling on both sides while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample every handshake at the rising edge; inputs only move on the falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) sb.note_item(item_ch.word);
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.word.reg_index, cfg_ch.word.wdata);
      if (res_ch.valid && res_ch.ready) sb.check_word(res_ch.word);
    end
  end

  // Stall the result side at random, 12 percent of the time, except in the calm stretch.
  always @(negedge clk) begin
    res_ch.ready = calm || ($urandom_range(99) >= 12);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_item(gmfe_pkg::item_t it);
    while (!calm && $urandom_range(99) < 12) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.word = it;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (it.operation == gmfe_pkg::OP_LOAD) loads_sent++;
    else evals_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.word.reg_index = idx;
    cfg_ch.word.wdata = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    reg_writes++;
  endtask

  // Hold the sender until every pending point has come back, then let the core settle.
  task automatic drain();
    item_ch.valid = 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic gmfe_pkg::item_t load_word(logic [3:0] idx, logic [30:0] amp,
                                                logic [31:0] a, logic [31:0] b,
                                                logic [31:0] d);
    gmfe_pkg::item_t it;
    logic [223:0]    noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(gmfe_pkg::item_t)-1:0];
    it.operation = gmfe_pkg::OP_LOAD;
    it.comp_index = idx;
    it.amp_value = amp;
    it.cov_a = a;
    it.cov_b = b;
    it.cov_d = d;
    return it;
  endfunction

  function automatic gmfe_pkg::item_t eval_word(logic [31:0] v, logic [31:0] w);
    gmfe_pkg::item_t it;
    logic [223:0]    noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(gmfe_pkg::item_t)-1:0];
    it.operation = gmfe_pkg::OP_EVAL;
    it.freq_v = v;
    it.freq_w = w;
    return it;
  endfunction

  // Frequencies mostly within +-1.0 so the Gaussian terms stay alive; some full range.
  function automatic logic [31:0] rand_freq();
    if ($urandom_range(99) < 20) return $urandom;
    return $urandom_range(32'h0200_0000) - 32'h0100_0000;
  endfunction

  // Covariances mostly small positive (exponents within range), some negative or wild.
  function automatic logic [31:0] rand_cov();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom;
    if (pick < 25) return -$urandom_range(32'h0000_4000);
    return $urandom_range(32'h0002_0000);
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 32'd16;
    if (pick < 12) return $urandom_range(17, 31) | ($urandom & 32'hFFFF_FFE0);
    if (pick < 15) return 32'd0;
    return $urandom_range(1, 4);
  endfunction

  initial begin
    gmfe_pkg::item_t it;
    sb = new();
    sb.reset_state();
    calm = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.word = '0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: fill every slot before any evaluate reads it, covering field extremes.
    send_item(load_word(4'd0, 31'h7FFF_FFFF, 32'd0, 32'd0, 32'd0));     // exp(0): full amplitude
    send_item(load_word(4'd1, 31'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(load_word(4'd2, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(load_word(4'd3, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    for (int k = 4; k < gmfe_pkg::MAX_COMP; k++)
      send_item(load_word(k[3:0], 31'($urandom), rand_cov(), rand_cov(), rand_cov()));
    // Reset count of one: only slot zero contributes.
    send_item(eval_word(32'd0, 32'd0));
    send_item(eval_word(32'h7FFF_FFFF, 32'h8000_0000));
    drain();

    // All sixteen slots, extreme offsets: saturated squares and huge exponents.
    write_reg(gmfe_pkg::REG_COUNT, 32'd16);
    write_reg(gmfe_pkg::REG_OFFSET_X, 32'h7FFF_FFFF);
    write_reg(gmfe_pkg::REG_OFFSET_Y, 32'h8000_0000);
    send_item(eval_word(32'h8000_0000, 32'h7FFF_FFFF));
    send_item(eval_word(32'h0080_0000, 32'hFF80_0000));
    send_item(eval_word(32'd0, 32'd0));
    drain();

    // Count zero gives zero outputs; an unknown register index changes nothing.
    write_reg(gmfe_pkg::REG_COUNT, 32'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_item(eval_word(32'h0100_0000, 32'h0100_0000));
    drain();

    // Count above the table size saturates to the table size.
    write_reg(gmfe_pkg::REG_COUNT, 32'd31);
    write_reg(gmfe_pkg::REG_OFFSET_X, 32'h0040_0000);
    write_reg(gmfe_pkg::REG_OFFSET_Y, 32'hFFC0_0000);
    send_item(eval_word(32'h0100_0000, 32'hFF00_0000));
    drain();

    // Random phases: new register settings between phases, loads and evaluates mixed.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(gmfe_pkg::REG_OFFSET_X, rand_offset());
      write_reg(gmfe_pkg::REG_OFFSET_Y, rand_offset());
      write_reg(gmfe_pkg::REG_COUNT, rand_count());
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, $urandom);
      calm = (ph == 3);   // one long stretch with no idling on either side
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1)) it = eval_word(rand_freq(), rand_freq());
        else it = load_word(4'($urandom), 31'($urandom), rand_cov(), rand_cov(), rand_cov());
        send_item(it);
      end
      calm = 1'b0;
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("covered %0d loads, %0d evaluates and %0d register writes over %0d settings",
             loads_sent, evals_sent, reg_writes, PHASES + 4);
    $display("%0d points checked, %0d mismatches, %0d still pending",
             sb.points_checked, sb.mismatches, sb.pending_points.size());
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
design/gmfe_pkg.sv
design/gmfe_ifs.sv
design/gmfe_mul.sv
design/gmfe_tbl.sv
design/gmfe_core.sv
design/gaussian_mixture_fourier_eval_top.sv
test/tb_gaussian_mixture_fourier_eval_top.sv
